@@ rtl/bbs_pkg.sv @@
package bbs_pkg;

    localparam int MAP_BITS_DEFAULT  = 65536;
    localparam int WORD_BITS_DEFAULT = 64;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 32;
    localparam int LEN_W   = 17;
    localparam int STAT_W  = 2;
    localparam int SIZE_W  = 14;
    localparam int POS_W   = SIZE_W + 3;

    localparam int MAX_RUN = 64;

    localparam logic [CMD_W-1:0] CMD_SET_BIT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLR_BIT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET_BIT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_RANGE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLR_RANGE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TEST_ZERO = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_READY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_BASE,
        S_MODIFY,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_SET,
        OP_CLR,
        OP_TEST
    } op_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear_start;
    } mem_ctl_t;

endpackage

@@ rtl/bbs_channels.sv @@
interface bbs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [bbs_pkg::CMD_W-1:0]    command;
    logic [bbs_pkg::INDEX_W-1:0]  bit_index;
    logic [bbs_pkg::LEN_W-1:0]    run_length;

    modport source (output valid, output command, output bit_index, output run_length,
                    input ready);
    modport sink (input valid, input command, input bit_index, input run_length,
                  output ready);
endinterface

interface bbs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         bit_result;
    logic [bbs_pkg::STAT_W-1:0]   status;

    modport source (output valid, output bit_result, output status, input ready);
    modport sink (input valid, input bit_result, input status, output ready);
endinterface

interface bbs_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bbs_pkg::SIZE_W-1:0]   map_bytes;

    modport source (output valid, output map_bytes, input ready);
    modport sink (input valid, input map_bytes, output ready);
endinterface

@@ rtl/block_bitmap_store.sv @@
// channel  dir  handshake        payload
// cmd      in   valid / ready    command, bit_index, run_length
// rsp      out  valid / ready    bit_result, status
// cfg      in   valid / ready    map_bytes
//
// an item steps through PREP, BASE, a MODIFY read-modify-write loop over the memory words touched, and FINISH
// single-bit commands touch one word; ranges and zero-run tests walk the words
// from start / WORD_BITS to (end - 1) / WORD_BITS, end clamped to the map end
// reset and every map_bytes write start a clear pass that zeroes every word of the store
// cmd is held off during the clear pass; cfg is always ready
// the next item is taken while a result waits in the output register
module block_bitmap_store #(
    parameter int MAP_BITS  = bbs_pkg::MAP_BITS_DEFAULT,
    parameter int WORD_BITS = bbs_pkg::WORD_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bbs_cmd_if.sink    cmd,
    bbs_rsp_if.source  rsp,
    bbs_cfg_if.sink    cfg
);
    import bbs_pkg::*;

    localparam int DEPTH  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mem_ctl_t             mctl;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] rd_data;
    logic                 clearing;

    bbs_ctrl #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rsp      (rsp),
        .cfg      (cfg),
        .mctl     (mctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

    bbs_mem #(
        .DEPTH     (DEPTH),
        .ADDR_W    (ADDR_W),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .clearing (clearing)
    );

endmodule

@@ rtl/bbs_mem.sv @@
module bbs_mem #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_W    = 10,
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbs_pkg::mem_ctl_t    ctl,
    input  logic [ADDR_W-1:0]    rd_addr,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    output logic [WORD_BITS-1:0] rd_data,
    output logic                 clearing
);
    import bbs_pkg::*;

    logic [WORD_BITS-1:0] mem [0:DEPTH-1];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 clearing_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;

    // clear pass after reset and after every size write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (ctl.clear_start)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

@@ rtl/bbs_ctrl.sv @@
module bbs_ctrl #(
    parameter int MAP_BITS  = 65536,
    parameter int WORD_BITS = 64,
    parameter int ADDR_W    = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bbs_cmd_if.sink              cmd,
    bbs_rsp_if.source            rsp,
    bbs_cfg_if.sink              cfg,
    output bbs_pkg::mem_ctl_t    mctl,
    output logic [ADDR_W-1:0]    rd_addr,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [WORD_BITS-1:0] wr_data,
    input  logic [WORD_BITS-1:0] rd_data,
    input  logic                 clearing
);
    import bbs_pkg::*;

    localparam int CAP_BYTES = MAP_BITS / 8;
    localparam int OFF_W     = $clog2(WORD_BITS + 1);
    localparam int DIV_L     = $clog2(WORD_BITS);
    localparam int DIV_S     = POS_W + DIV_L;
    localparam int M_W       = POS_W + 2;
    localparam int PROD_W    = POS_W + M_W;
    localparam logic [M_W-1:0] DIV_M =
        M_W'(((64'd1 << DIV_S) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

    state_t state_reg, state_next;

    logic [CMD_W-1:0]   cmd_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               map_zero_reg;
    logic [POS_W-1:0]   lim_reg;
    op_t                op_reg;
    logic               walk_reg;
    logic               res_use_reg;
    logic               res_inv_reg;
    logic [STAT_W-1:0]  stat_reg;
    logic [POS_W-1:0]   s_reg;
    logic [POS_W-1:0]   e_reg;
    logic [POS_W-1:0]   q_reg;
    logic [POS_W-1:0]   b_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               or_acc_reg;
    logic               out_valid_reg;
    logic               out_bit_reg;
    logic [STAT_W-1:0]  out_stat_reg;

    logic cmd_fire, cfg_fire, out_free, out_load, last_word;

    // decode of the held item
    op_t               op_dec;
    logic [POS_W-1:0]  nlen;
    logic              known, res_use_dec, res_inv_dec, idx_in_map, walk_dec;
    logic [STAT_W-1:0] stat_dec;
    logic [INDEX_W:0]  sum;
    logic [POS_W-1:0]  e_dec;
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  q_dec;
    logic [POS_W-1:0]  b_base;
    logic [POS_W-1:0]  lim_dec;

    // word window
    logic [POS_W:0]       wend;
    logic [OFF_W-1:0]     lo, hi;
    logic [WORD_BITS-1:0] mask;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        lim_dec = {cfg.map_bytes, 3'b000};
        if (32'(cfg.map_bytes) > 32'(CAP_BYTES))
        begin
            lim_dec = POS_W'(CAP_BYTES * 8);
        end
    end

    always_comb
    begin
        op_dec      = OP_TEST;
        nlen        = '0;
        known       = 1'b0;
        res_use_dec = 1'b0;
        res_inv_dec = 1'b0;
        stat_dec    = STAT_OK;
        idx_in_map  = idx_reg < 32'(lim_reg);
        unique case (cmd_reg)
            CMD_SET_BIT, CMD_CLR_BIT:
            begin
                op_dec = (cmd_reg == CMD_SET_BIT) ? OP_SET : OP_CLR;
                nlen   = POS_W'(1);
                known  = 1'b1;
                if (map_zero_reg)
                begin
                    stat_dec = STAT_NOT_READY;
                end
                else if (!idx_in_map)
                begin
                    stat_dec = STAT_RANGE;
                end
            end
            CMD_GET_BIT:
            begin
                nlen        = POS_W'(1);
                known       = 1'b1;
                res_use_dec = !map_zero_reg;
                if (map_zero_reg)
                begin
                    stat_dec = STAT_NOT_READY;
                end
            end
            CMD_SET_RANGE, CMD_CLR_RANGE:
            begin
                op_dec = (cmd_reg == CMD_SET_RANGE) ? OP_SET : OP_CLR;
                nlen   = len_reg;
                known  = 1'b1;
            end
            CMD_TEST_ZERO:
            begin
                nlen        = (len_reg > LEN_W'(MAX_RUN)) ? POS_W'(MAX_RUN) : len_reg;
                known       = 1'b1;
                res_use_dec = !map_zero_reg;
                res_inv_dec = 1'b1;
                if (map_zero_reg)
                begin
                    stat_dec = STAT_NOT_READY;
                end
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
        sum      = (INDEX_W + 1)'(idx_reg) + (INDEX_W + 1)'(nlen);
        e_dec    = (sum < (INDEX_W + 1)'(lim_reg)) ? sum[POS_W-1:0] : lim_reg;
        walk_dec = known && idx_in_map && (nlen != '0);
        prod     = PROD_W'(idx_reg[POS_W-1:0]) * PROD_W'(DIV_M);
        q_dec    = POS_W'(prod >> DIV_S);
        b_base   = POS_W'(32'(q_reg) * 32'(WORD_BITS));
    end

    always_comb
    begin
        wend      = {1'b0, b_reg} + (POS_W + 1)'(WORD_BITS);
        last_word = wend >= {1'b0, e_reg};
        lo        = (s_reg > b_reg) ? OFF_W'(s_reg - b_reg) : '0;
        hi        = ({1'b0, e_reg} < wend) ? OFF_W'(e_reg - b_reg) : OFF_W'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[WORD_BITS-1-i] = (OFF_W'(i) >= lo) && (OFF_W'(i) < hi);
        end
        wr_data = (op_reg == OP_SET) ? (rd_data | mask) : (rd_data & ~mask);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:   state_next = S_BASE;
            S_BASE:   state_next = walk_reg ? S_MODIFY : S_FINISH;
            S_MODIFY:
            begin
                if (last_word)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.ready        = (state_reg == S_IDLE) && !clearing && !cfg.valid;
        mctl.rd_en       = ((state_reg == S_BASE) && walk_reg)
                         || ((state_reg == S_MODIFY) && !last_word);
        mctl.wr_en       = (state_reg == S_MODIFY) && (op_reg != OP_TEST);
        mctl.clear_start = cfg_fire;
        out_load         = (state_reg == S_FINISH) && out_free;
        rd_addr          = (state_reg == S_BASE) ? ADDR_W'(q_reg) : addr_reg + 1'b1;
        wr_addr          = addr_reg;
    end

    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.bit_result = out_bit_reg;
    assign rsp.status     = out_stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            map_zero_reg  <= 1'b1;
            lim_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_fire)
            begin
                map_zero_reg <= (cfg.map_bytes == '0);
                lim_reg      <= lim_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg <= cmd.command;
            idx_reg <= cmd.bit_index;
            len_reg <= cmd.run_length;
        end
        if (state_reg == S_PREP)
        begin
            op_reg      <= op_dec;
            walk_reg    <= walk_dec;
            res_use_reg <= res_use_dec;
            res_inv_reg <= res_inv_dec;
            stat_reg    <= stat_dec;
            s_reg       <= idx_reg[POS_W-1:0];
            e_reg       <= e_dec;
            q_reg       <= q_dec;
            or_acc_reg  <= 1'b0;
        end
        if (state_reg == S_BASE)
        begin
            b_reg    <= b_base;
            addr_reg <= ADDR_W'(q_reg);
        end
        if (state_reg == S_MODIFY)
        begin
            or_acc_reg <= or_acc_reg | (|(rd_data & mask));
            if (!last_word)
            begin
                b_reg    <= wend[POS_W-1:0];
                addr_reg <= addr_reg + 1'b1;
            end
        end
        if (out_load)
        begin
            out_bit_reg  <= res_use_reg & (or_acc_reg ^ res_inv_reg);
            out_stat_reg <= stat_reg;
        end
    end

`ifndef SYNTH
    a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        mctl.wr_en |-> $past(mctl.rd_en) && (wr_addr == $past(rd_addr)))
        else $error("write back not at the word just read");

    a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mctl.wr_en |-> !clearing)
        else $error("store write during clear pass");

    a_not_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (stat_reg == STAT_NOT_READY) |-> map_zero_reg)
        else $error("not_ready with a nonzero map size");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result appeared outside finish");
`endif

endmodule
